// ----- rtl/kdls_pkg.sv -----
// Shared types, widths and constants for the key debounce lockout scanner.
package kdls_pkg;

  localparam int unsigned NUM_CELLS_DEF = 16;
  localparam int unsigned LEVEL_W       = 16;
  localparam int unsigned TIME_W        = 64;
  localparam int unsigned CFG_W         = 24;
  localparam int unsigned COUNT_W       = 32;
  localparam int unsigned CFG_IDX_W     = 2;

  // Item function codes.
  localparam logic FUNC_SCAN   = 1'b0;
  localparam logic FUNC_RESYNC = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GIVEUP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] SETTLE_RST  = 24'd5000;
  localparam logic [CFG_W-1:0] GIVEUP_RST  = 24'd50000;
  localparam logic [CFG_W-1:0] LOCKOUT_RST = 24'd30000;

  typedef struct packed {
    logic               func;
    logic [LEVEL_W-1:0] cell_levels_n;
    logic [TIME_W-1:0]  time_us;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] key_down_mask;
    logic [LEVEL_W-1:0] held_keys;
    logic [COUNT_W-1:0] total_presses;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] release_settle_us;
    logic [CFG_W-1:0] release_giveup_us;
    logic [CFG_W-1:0] press_lockout_us;
  } cfg_t;

  typedef struct packed {
    logic key_down;
    logic held;
  } lane_stat_t;

endpackage

// ----- rtl/kdls_lane.sv -----
// Per-cell debounce and lockout lane: one cell's state and its update.
module kdls_lane (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step_en,
  input  logic                     func,
  input  logic                     pressed,
  input  logic [kdls_pkg::TIME_W-1:0] now,
  input  kdls_pkg::cfg_t           cfg,
  output kdls_pkg::lane_stat_t     stat
);

  logic                        held_r, held_nxt;
  logic                        open_seen_r, open_seen_nxt;
  logic [kdls_pkg::TIME_W-1:0] lockout_end_r, lockout_end_nxt;
  logic [kdls_pkg::TIME_W-1:0] last_closed_r, last_closed_nxt;
  logic [kdls_pkg::TIME_W-1:0] first_open_r, first_open_nxt;
  logic [kdls_pkg::TIME_W-1:0] first_open_eff;
  logic                        settle_hit;
  logic                        giveup_hit;
  logic                        key_down;

  // The first open reading of a held cell starts the give-up window now.
  assign first_open_eff = open_seen_r ? first_open_r : now;
  assign settle_hit = (now - last_closed_r) >=
                      kdls_pkg::TIME_W'(cfg.release_settle_us);
  assign giveup_hit = (now - first_open_eff) >=
                      kdls_pkg::TIME_W'(cfg.release_giveup_us);

  always_comb begin
    held_nxt        = held_r;
    open_seen_nxt   = open_seen_r;
    lockout_end_nxt = lockout_end_r;
    last_closed_nxt = last_closed_r;
    first_open_nxt  = first_open_r;
    key_down        = 1'b0;
    if (func == kdls_pkg::FUNC_RESYNC) begin
      held_nxt        = pressed;
      open_seen_nxt   = 1'b0;
      lockout_end_nxt = now;
      last_closed_nxt = now;
      first_open_nxt  = now;
    end else if (held_r) begin
      if (pressed) begin
        last_closed_nxt = now;
      end else begin
        open_seen_nxt  = 1'b1;
        first_open_nxt = first_open_eff;
        if (settle_hit || giveup_hit) begin
          held_nxt      = 1'b0;
          open_seen_nxt = 1'b0;
        end
      end
    end else if (pressed && (now >= lockout_end_r)) begin
      held_nxt        = 1'b1;
      open_seen_nxt   = 1'b0;
      last_closed_nxt = now;
      lockout_end_nxt = now + kdls_pkg::TIME_W'(cfg.press_lockout_us);
      key_down        = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r        <= 1'b0;
      open_seen_r   <= 1'b0;
      lockout_end_r <= '0;
      last_closed_r <= '0;
      first_open_r  <= '0;
    end else if (step_en) begin
      held_r        <= held_nxt;
      open_seen_r   <= open_seen_nxt;
      lockout_end_r <= lockout_end_nxt;
      last_closed_r <= last_closed_nxt;
      first_open_r  <= first_open_nxt;
    end
  end

  assign stat.key_down = key_down;
  assign stat.held     = held_nxt;

endmodule

// ----- rtl/kdls_merge.sv -----
// Merge stage: counts lane presses, forms the result and queues it for output.
module kdls_merge #(
  parameter int unsigned NUM_CELLS = kdls_pkg::NUM_CELLS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  logic                    func,
  input  logic [NUM_CELLS-1:0]    key_down,
  input  logic [NUM_CELLS-1:0]    held,
  output logic                    push_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  output kdls_pkg::out_item_t     out_data
);

  localparam int unsigned CNT_W = $clog2(NUM_CELLS + 1);

  logic [kdls_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0]             presses;
  logic [kdls_pkg::LEVEL_W-1:0] down_mask;
  logic [kdls_pkg::LEVEL_W-1:0] held_mask;
  kdls_pkg::out_item_t          result;

  // Two-entry result queue so a stalled receiver does not stop intake at once.
  kdls_pkg::out_item_t q_r [2];
  logic                wr_ptr_r, rd_ptr_r;
  logic [1:0]          fill_r;
  logic                pop;

  always_comb begin
    presses = '0;
    for (int i = 0; i < NUM_CELLS; i++) begin
      presses = presses + CNT_W'(key_down[i]);
    end
  end

  for (genvar g = 0; g < kdls_pkg::LEVEL_W; g++) begin : g_mask
    if (g < NUM_CELLS) begin : g_live
      assign down_mask[g] = key_down[g];
      assign held_mask[g] = held[g];
    end else begin : g_none
      assign down_mask[g] = 1'b0;
      assign held_mask[g] = 1'b0;
    end
  end

  assign count_nxt = (func == kdls_pkg::FUNC_RESYNC) ? '0 :
                     count_r + kdls_pkg::COUNT_W'(presses);

  assign result.key_down_mask = down_mask;
  assign result.held_keys     = held_mask;
  assign result.total_presses = count_nxt;

  assign push_ready = (fill_r != 2'd2);
  assign out_valid  = (fill_r != 2'd0);
  assign out_data   = q_r[rd_ptr_r];
  assign pop        = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        count_r  <= count_nxt;
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= result;
    end
  end

endmodule

// ----- rtl/key_debounce_lockout_scanner.sv -----
// Top level of the key debounce lockout scanner: config registers, lanes, merge.
//
// Usage: each input transaction (in_valid/in_ready, payload in_data) carries a
// function code, one active-low level bit per cell and a 64-bit microsecond
// timestamp. A scan transaction debounces every cell; a resync transaction
// loads the held state from the current levels, clears the press count and
// sets every per-cell time to the timestamp. Every input transaction yields
// exactly one output transaction (out_valid/out_ready, payload out_data) with
// the new key-down mask, the held mask and the running press count.
// One lane per cell updates its state in the cycle the transaction is taken,
// so the block accepts one transaction per cycle while in_ready is high; its
// result is written into the two-entry output queue as it is taken: intake
// continues while fewer than two results wait, and in_ready is low in every
// cycle that both entries are full, whatever out_ready does then.
// Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are always
// accepted; index 0 is the settle window, 1 the give-up ceiling, 2 the press
// lockout, and index 3 is ignored. Write them only while the block is idle.
// Synchronous active-low reset clears all cell state, the count and the queue,
// and restores the registers to 5000, 50000 and 30000 microseconds.
module key_debounce_lockout_scanner #(
  parameter int unsigned NUM_CELLS = kdls_pkg::NUM_CELLS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  kdls_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output kdls_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [kdls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kdls_pkg::CFG_W-1:0]     cfg_data
);

  kdls_pkg::cfg_t       cfg_r;
  logic                 step_en;
  logic [NUM_CELLS-1:0] pressed;
  logic [NUM_CELLS-1:0] key_down;
  logic [NUM_CELLS-1:0] held;

  // Configuration registers; the port never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.release_settle_us <= kdls_pkg::SETTLE_RST;
      cfg_r.release_giveup_us <= kdls_pkg::GIVEUP_RST;
      cfg_r.press_lockout_us  <= kdls_pkg::LOCKOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        kdls_pkg::REG_SETTLE:  cfg_r.release_settle_us <= cfg_data;
        kdls_pkg::REG_GIVEUP:  cfg_r.release_giveup_us <= cfg_data;
        kdls_pkg::REG_LOCKOUT: cfg_r.press_lockout_us  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign step_en = in_valid && in_ready;

  // A contact reads pressed when its level is low. Cells past the level field
  // have no contact wired and always read pressed.
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_lane
    kdls_pkg::lane_stat_t stat;

    if (g < kdls_pkg::LEVEL_W) begin : g_wired
      assign pressed[g] = ~in_data.cell_levels_n[g];
    end else begin : g_unwired
      assign pressed[g] = 1'b1;
    end

    kdls_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .step_en (step_en),
      .func    (in_data.func),
      .pressed (pressed[g]),
      .now     (in_data.time_us),
      .cfg     (cfg_r),
      .stat    (stat)
    );

    assign key_down[g] = stat.key_down;
    assign held[g]     = stat.held;
  end

  // Merge stage: press count, result formatting and the output queue.
  kdls_merge #(
    .NUM_CELLS (NUM_CELLS)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (step_en),
    .func       (in_data.func),
    .key_down   (key_down),
    .held       (held),
    .push_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ----- dv/kdls_result_check.sv -----
// Result checker for the key debounce lockout scanner: predicts each result and compares.
`timescale 1ns / 1ps

module kdls_result_check (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  kdls_pkg::in_item_t             in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  kdls_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [kdls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kdls_pkg::CFG_W-1:0]     cfg_data,
  output int unsigned                    pending,
  output int unsigned                    mismatch_count
);

  localparam int unsigned CELLS = kdls_pkg::NUM_CELLS_DEF;

  logic [kdls_pkg::CFG_W-1:0]   settle_us;
  logic [kdls_pkg::CFG_W-1:0]   giveup_us;
  logic [kdls_pkg::CFG_W-1:0]   lockout_us;
  logic [CELLS-1:0]             held_q;
  logic [CELLS-1:0]             open_seen_q;
  logic [kdls_pkg::COUNT_W-1:0] press_total;
  logic [kdls_pkg::TIME_W-1:0]  lock_end [CELLS];
  logic [kdls_pkg::TIME_W-1:0]  last_closed [CELLS];
  logic [kdls_pkg::TIME_W-1:0]  first_open [CELLS];

  kdls_pkg::out_item_t predicted_scans[$];

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // Advances the predicted cell state by one transaction and returns its result.
  task automatic debounce_step(input kdls_pkg::in_item_t item,
                               output kdls_pkg::out_item_t res);
    logic [CELLS-1:0]            pressed;
    logic [CELLS-1:0]            down;
    logic [kdls_pkg::TIME_W-1:0] stamp;
    logic [kdls_pkg::TIME_W-1:0] closed_age;
    logic [kdls_pkg::TIME_W-1:0] open_age;
    int i;
    pressed = ~item.cell_levels_n;
    stamp   = item.time_us;
    down    = '0;
    if (item.func == kdls_pkg::FUNC_RESYNC) begin
      held_q      = pressed;
      open_seen_q = '0;
      press_total = '0;
      for (i = 0; i < CELLS; i++) begin
        lock_end[i]    = stamp;
        last_closed[i] = stamp;
        first_open[i]  = stamp;
      end
    end else begin
      for (i = 0; i < CELLS; i++) begin
        if (held_q[i]) begin
          if (pressed[i]) begin
            last_closed[i] = stamp;
          end else begin
            if (!open_seen_q[i]) begin
              open_seen_q[i] = 1'b1;
              first_open[i]  = stamp;
            end
            closed_age = stamp - last_closed[i];
            open_age   = stamp - first_open[i];
            if (closed_age >= {40'b0, settle_us} || open_age >= {40'b0, giveup_us}) begin
              held_q[i]      = 1'b0;
              open_seen_q[i] = 1'b0;
            end
          end
        end else if (stamp >= lock_end[i] && pressed[i]) begin
          held_q[i]      = 1'b1;
          open_seen_q[i] = 1'b0;
          last_closed[i] = stamp;
          lock_end[i]    = stamp + {40'b0, lockout_us};
          down[i]        = 1'b1;
          press_total    = press_total + kdls_pkg::COUNT_W'(1);
        end
      end
    end
    res.key_down_mask = down;
    res.held_keys     = held_q;
    res.total_presses = press_total;
  endtask

  always @(posedge clk) begin
    kdls_pkg::out_item_t want;
    kdls_pkg::out_item_t got;
    int i;
    if (!rst_n) begin
      settle_us      = kdls_pkg::SETTLE_RST;
      giveup_us      = kdls_pkg::GIVEUP_RST;
      lockout_us     = kdls_pkg::LOCKOUT_RST;
      held_q         = '0;
      open_seen_q    = '0;
      press_total    = '0;
      mismatch_count = 0;
      for (i = 0; i < CELLS; i++) begin
        lock_end[i]    = '0;
        last_closed[i] = '0;
        first_open[i]  = '0;
      end
      predicted_scans.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_scans.size() == 0) begin
          flag_mismatch($sformatf("result %h with nothing expected", out_data));
        end else begin
          want = predicted_scans.pop_front();
          if (out_data.key_down_mask !== want.key_down_mask) begin
            flag_mismatch($sformatf("key_down_mask got %h want %h",
                                    out_data.key_down_mask, want.key_down_mask));
          end
          if (out_data.held_keys !== want.held_keys) begin
            flag_mismatch($sformatf("held_keys got %h want %h",
                                    out_data.held_keys, want.held_keys));
          end
          if (out_data.total_presses !== want.total_presses) begin
            flag_mismatch($sformatf("total_presses got %0d want %0d",
                                    out_data.total_presses, want.total_presses));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          kdls_pkg::REG_SETTLE:  settle_us  = cfg_data;
          kdls_pkg::REG_GIVEUP:  giveup_us  = cfg_data;
          kdls_pkg::REG_LOCKOUT: lockout_us = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        debounce_step(in_data, got);
        predicted_scans.push_back(got);
      end
    end
    pending = predicted_scans.size();
  end

endmodule

// ----- dv/testbench.sv -----
// Top of the key debounce lockout scanner testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

  // Index 3 has no register behind it; writes there must be dropped.
  localparam logic [kdls_pkg::CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;
  localparam logic [kdls_pkg::CFG_W-1:0]     CFG_MAX     = 24'hFF_FFFF;
  localparam int unsigned                    CYCLE_LIMIT = 300000;
  // Start of the wrap test: lockouts armed here end past 2^64.
  localparam logic [kdls_pkg::TIME_W-1:0]    NEAR_WRAP   =
    64'hFFFF_FFFF_FFFF_FFFF - 64'd19999;

  logic clk = 1'b0;
  logic rst_n;

  logic                           in_valid;
  logic                           in_ready;
  kdls_pkg::in_item_t             in_data;
  logic                           out_valid;
  logic                           out_ready;
  kdls_pkg::out_item_t            out_data;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [kdls_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [kdls_pkg::CFG_W-1:0]     cfg_data;

  int unsigned pending;
  int unsigned mismatch_total;
  int unsigned cycle_count = 0;

  // Burst flags switch idling off on either side for a stretch of transactions.
  bit tx_burst;
  bit rx_burst;

  // Physical contact state of the keypad (1 = closed) and the running clock.
  logic [kdls_pkg::LEVEL_W-1:0] contacts;
  logic [kdls_pkg::TIME_W-1:0]  now_us;

  always #5 clk = ~clk;

  key_debounce_lockout_scanner u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  kdls_result_check u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pending        (pending),
    .mismatch_count (mismatch_total)
  );

  // Watchdog: a hung handshake or a lost result ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result receiver. Ready is held low by a random stall before each transaction,
  // except during bursts, when ready stays high. Ready is only ever changed at the
  // falling edge and only once per edge.
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    rx_burst  = 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 31) == 0) begin
        rx_burst = ~rx_burst;
      end
      stall = rx_burst ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Offers one input transaction after a random gap and returns at the falling
  // edge after it was taken. Valid stays high into the next call when that call
  // draws no gap, so back-to-back transactions are possible.
  task automatic send_item(input logic fn, input logic [kdls_pkg::LEVEL_W-1:0] levels,
                           input logic [kdls_pkg::TIME_W-1:0] stamp);
    kdls_pkg::in_item_t item;
    int unsigned        gap;
    item.func          = fn;
    item.cell_levels_n = levels;
    item.time_us       = stamp;
    if ($urandom_range(0, 31) == 0) begin
      tx_burst = ~tx_burst;
    end
    gap = tx_burst ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [kdls_pkg::CFG_IDX_W-1:0] idx,
                           input logic [kdls_pkg::CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Waits until every predicted result has been seen, then lets the output
  // queue and the lanes settle. Input valid must already be low.
  task automatic wait_quiet();
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Reprograms all three windows while the block is idle. The unused index is
  // written too, with random data, to check that it changes nothing.
  task automatic load_config(input logic [kdls_pkg::CFG_W-1:0] settle,
                             input logic [kdls_pkg::CFG_W-1:0] giveup,
                             input logic [kdls_pkg::CFG_W-1:0] lockout);
    in_valid <= 1'b0;
    wait_quiet();
    write_reg(REG_UNUSED, kdls_pkg::CFG_W'($urandom));
    write_reg(kdls_pkg::REG_SETTLE, settle);
    write_reg(kdls_pkg::REG_GIVEUP, giveup);
    write_reg(kdls_pkg::REG_LOCKOUT, lockout);
    cfg_valid <= 1'b0;
  endtask

  // One random phase. Keys are pressed and released on a simulated keypad
  // with contact bounce layered on top, and the clock advances in steps scaled
  // to the windows so that settle, give-up and lockout all come into play.
  // A few transactions jump the clock anywhere, run it up to the 64-bit wrap,
  // hold it still, feed random levels or resync.
  task automatic run_phase(input logic [kdls_pkg::CFG_W-1:0] settle,
                           input logic [kdls_pkg::CFG_W-1:0] giveup,
                           input logic [kdls_pkg::CFG_W-1:0] lockout,
                           input int unsigned items);
    int unsigned                  scale;
    int unsigned                  n;
    int                           c;
    logic [kdls_pkg::LEVEL_W-1:0] bounce;
    logic [kdls_pkg::LEVEL_W-1:0] levels;
    logic                         fn;
    load_config(settle, giveup, lockout);
    scale = 32'(settle);
    if (giveup > scale) scale = 32'(giveup);
    if (lockout > scale) scale = 32'(lockout);
    if (scale < 64) scale = 64;
    for (n = 0; n < items; n++) begin
      case ($urandom_range(0, 19))
        0: now_us = {$urandom, $urandom};
        1: now_us = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, scale));
        2: ;
        default: now_us = now_us + 64'($urandom_range(0, scale / 3 + 1));
      endcase
      for (c = 0; c < kdls_pkg::LEVEL_W; c++) begin
        if ($urandom_range(0, 5) == 0) contacts[c] = ~contacts[c];
      end
      bounce = ($urandom_range(0, 3) == 0) ?
               kdls_pkg::LEVEL_W'($urandom & $urandom & $urandom) : '0;
      levels = ~contacts ^ bounce;
      if ($urandom_range(0, 39) == 0) levels = kdls_pkg::LEVEL_W'($urandom);
      fn = ($urandom_range(0, 29) == 0) ? kdls_pkg::FUNC_RESYNC : kdls_pkg::FUNC_SCAN;
      send_item(fn, levels, now_us);
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    tx_burst    = 1'b0;
    contacts    = '0;
    now_us      = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, default windows: the unused index is written first, then
    // press, hold, release on settle, a press inside the lockout and a press
    // right at its end.
    write_reg(REG_UNUSED, CFG_MAX);
    cfg_valid <= 1'b0;
    send_item(kdls_pkg::FUNC_SCAN, 16'hFFFF, 64'd0);
    send_item(kdls_pkg::FUNC_SCAN, 16'h0000, 64'd0);
    send_item(kdls_pkg::FUNC_SCAN, 16'hFFFF, 64'd100);
    send_item(kdls_pkg::FUNC_SCAN, 16'hFFFF, 64'd6000);
    send_item(kdls_pkg::FUNC_SCAN, 16'h0000, 64'd10000);
    send_item(kdls_pkg::FUNC_SCAN, 16'h0000, 64'd30000);
    send_item(kdls_pkg::FUNC_SCAN, 16'h5555, 64'd31000);
    send_item(kdls_pkg::FUNC_SCAN, 16'h5555, 64'd34000);
    send_item(kdls_pkg::FUNC_SCAN, 16'hFFFF, 64'd35000);

    // Give-up release: the settle window never closes, but a key that keeps
    // bouncing is forced open once it has been open long enough. No lockout.
    load_config(CFG_MAX, 24'd2000, 24'd0);
    send_item(kdls_pkg::FUNC_SCAN, 16'h0000, 64'd100000);
    send_item(kdls_pkg::FUNC_SCAN, 16'hFFFF, 64'd100500);
    send_item(kdls_pkg::FUNC_SCAN, 16'h0000, 64'd101000);
    send_item(kdls_pkg::FUNC_SCAN, 16'hFFFF, 64'd102600);
    send_item(kdls_pkg::FUNC_SCAN, 16'h0000, 64'd102600);

    // Resync near the top of the time range. The lockout set by the next press
    // wraps past 2^64 and so is over at once; then the clock itself wraps.
    load_config(kdls_pkg::SETTLE_RST, kdls_pkg::GIVEUP_RST, kdls_pkg::LOCKOUT_RST);
    send_item(kdls_pkg::FUNC_RESYNC, 16'h00FF, NEAR_WRAP);
    send_item(kdls_pkg::FUNC_SCAN, 16'h0000, NEAR_WRAP + 64'd1000);
    send_item(kdls_pkg::FUNC_SCAN, 16'hFFFF, NEAR_WRAP + 64'd1010);
    send_item(kdls_pkg::FUNC_SCAN, 16'hFFFF, NEAR_WRAP + 64'd7000);
    send_item(kdls_pkg::FUNC_SCAN, 16'h0000, NEAR_WRAP + 64'd8000);
    send_item(kdls_pkg::FUNC_SCAN, 16'hFFFF, NEAR_WRAP + 64'd20100);
    send_item(kdls_pkg::FUNC_RESYNC, 16'hFFFF, 64'd0);

    // Random phases over a spread of window settings, extremes included.
    now_us = 64'd0;
    run_phase(kdls_pkg::SETTLE_RST, kdls_pkg::GIVEUP_RST, kdls_pkg::LOCKOUT_RST, 250);
    run_phase(24'd0, 24'd0, 24'd0, 250);
    run_phase(CFG_MAX, CFG_MAX, CFG_MAX, 250);
    run_phase(CFG_MAX, 24'($urandom_range(1000, 20000)), 24'($urandom_range(0, 20000)), 250);
    run_phase(24'($urandom_range(0, 20000)), 24'($urandom_range(0, 20000)),
              24'($urandom_range(0, 20000)), 250);
    run_phase(24'($urandom), 24'($urandom), 24'($urandom), 250);
    run_phase(24'd0, CFG_MAX, 24'd0, 250);

    in_valid <= 1'b0;
    wait_quiet();
    repeat (8) @(negedge clk);
    if (mismatch_total == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- key_debounce_lockout_scanner.f -----
rtl/kdls_pkg.sv
rtl/kdls_lane.sv
rtl/kdls_merge.sv
rtl/key_debounce_lockout_scanner.sv
dv/kdls_result_check.sv
dv/testbench.sv
